### rtl/wma_pkg.sv
// Shared constants and controller/datapath interface types for the moving average core.
package wma_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int SLOT_W     = $clog2(MAX_WINDOW);
   localparam int LEN_W      = 7;
   localparam int X_W        = 32;
   localparam int Y_W        = 16;
   localparam int SUM_W      = Y_W + SLOT_W + 1;
   localparam int MAG_W      = SUM_W - 1;
   localparam int DCNT_W     = $clog2(MAG_W);

   localparam logic [LEN_W-1:0] LEN_RESET = 7'd12;
   localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_WINDOW);

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic capture;
      logic update;
      logic div_step;
      logic out_load;
   } wma_cmd_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic result_due;
      logic div_last;
      logic out_busy;
   } wma_stat_type;

endpackage

### rtl/wma_ctrl.sv
// Sequencer for the moving average core: steps each transaction through read, update and divide.
module wma_ctrl import wma_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output wma_cmd_type  cmd,
   input  wma_stat_type stat
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   // Decode commands and the next state
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (ready_ff && req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = stat.result_due ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_tready = ready_ff;

endmodule

### rtl/wma_dp.sv
// Datapath for the moving average core: delay lines, running sum, midpoint, divider, output register.
module wma_dp import wma_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [X_W+Y_W-1:0]   req_tdata,
   input  logic                 req_tuser,
   input  logic                 csr_wr_en,
   input  logic [LEN_W-1:0]     csr_wr_data,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [X_W+Y_W-1:0]   rsp_tdata,
   input  wma_cmd_type          cmd,
   output wma_stat_type         stat
);

   // Delay line memories
   logic [Y_W-1:0]    sample_mem [MAX_WINDOW];
   logic [X_W-1:0]    time_mem   [MAX_WINDOW];
   logic [Y_W-1:0]    old_y_rd_ff;
   logic [X_W-1:0]    old_x_rd_ff;

   logic [LEN_W-1:0]  len_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [LEN_W-1:0]  fill_ff;
   logic [SLOT_W-1:0] wslot_ff;

   logic [X_W-1:0]    x_ff;
   logic [Y_W-1:0]    y_ff;
   logic [X_W-1:0]    mid_ff;

   logic              neg_ff;
   logic [MAG_W-1:0]  quot_ff;
   logic [LEN_W-1:0]  rem_ff;
   logic [DCNT_W-1:0] dcnt_ff;

   logic              out_valid_ff;
   logic [X_W+Y_W-1:0] out_data_ff;

   logic [LEN_W-1:0]  len_eff;
   logic [SLOT_W-1:0] next_slot;
   logic              full;
   logic [SUM_W-1:0]  sum_new;
   logic [LEN_W-1:0]  fill_new;
   logic [SUM_W-1:0]  sum_abs;
   logic [X_W-1:0]    old_x;
   logic [X_W:0]      span;
   logic [X_W:0]      half;
   logic [LEN_W:0]    trial;
   logic              trial_ge;
   logic [Y_W-1:0]    avg;

   // Saturate the configured window length into 1..MAX_WINDOW
   always_comb begin
      if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = len_ff;
      end
   end

   // Ring slot after the one being written; it holds the oldest entry once full
   assign next_slot = ({1'b0, wslot_ff} + 7'd1 == len_eff) ? '0 : wslot_ff + SLOT_W'(1);

   // Window update
   assign full     = (fill_ff == len_eff);
   assign sum_new  = sum_ff + {{(SUM_W-Y_W){y_ff[Y_W-1]}}, y_ff}
                     - (full ? {{(SUM_W-Y_W){old_y_rd_ff[Y_W-1]}}, old_y_rd_ff} : '0);
   assign fill_new = full ? fill_ff : fill_ff + LEN_W'(1);
   assign sum_abs  = sum_new[SUM_W-1] ? (~sum_new + SUM_W'(1)) : sum_new;

   // Midpoint: oldest plus the floored half of the signed span
   assign old_x = (len_eff == LEN_W'(1)) ? x_ff : old_x_rd_ff;
   assign span  = {1'b0, x_ff} - {1'b0, old_x};
   assign half  = {span[X_W], span[X_W:1]};

   // Restoring division step: one quotient bit per cycle
   assign trial    = {rem_ff, quot_ff[MAG_W-1]};
   assign trial_ge = (trial >= {1'b0, len_eff});

   assign avg = neg_ff ? (~quot_ff[Y_W-1:0] + Y_W'(1)) : quot_ff[Y_W-1:0];

   // Read both delay lines at the current and oldest slots
   always_ff @(posedge clock) begin
      old_y_rd_ff <= sample_mem[wslot_ff];
      old_x_rd_ff <= time_mem[next_slot];
   end

   // Write the new pair into the ring
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         sample_mem[wslot_ff] <= y_ff;
         time_mem[wslot_ff]   <= x_ff;
      end
   end

   // Window state: length register, running sum, fill count, write slot
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= LEN_RESET;
         sum_ff   <= '0;
         fill_ff  <= '0;
         wslot_ff <= '0;
      end else if (csr_wr_en) begin
         len_ff   <= csr_wr_data;
         sum_ff   <= '0;
         fill_ff  <= '0;
         wslot_ff <= '0;
      end else if (cmd.capture) begin
         // A new series empties the window; otherwise keep slot and count in range
         if (req_tuser) begin
            sum_ff   <= '0;
            fill_ff  <= '0;
            wslot_ff <= '0;
         end else begin
            if ({1'b0, wslot_ff} >= len_eff) begin
               wslot_ff <= '0;
            end
            if (fill_ff > len_eff) begin
               fill_ff <= len_eff;
            end
         end
      end else if (cmd.update) begin
         sum_ff   <= sum_new;
         fill_ff  <= fill_new;
         wslot_ff <= next_slot;
      end
   end

   // Item, midpoint and divider registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= req_tdata[X_W-1:0];
         y_ff <= req_tdata[X_W+Y_W-1:X_W];
      end
      if (cmd.update) begin
         mid_ff  <= old_x + half[X_W-1:0];
         neg_ff  <= sum_new[SUM_W-1];
         quot_ff <= sum_abs[MAG_W-1:0];
         rem_ff  <= '0;
         dcnt_ff <= DCNT_W'(MAG_W - 1);
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[MAG_W-2:0], trial_ge};
         rem_ff  <= trial_ge ? LEN_W'(trial - {1'b0, len_eff}) : trial[LEN_W-1:0];
         dcnt_ff <= dcnt_ff - DCNT_W'(1);
      end
   end

   // Output register: load a result, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_data_ff <= {mid_ff, avg};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign stat.result_due = (fill_new == len_eff);
   assign stat.div_last   = (dcnt_ff == '0);
   assign stat.out_busy   = out_valid_ff && !rsp_tready;

endmodule

### rtl/windowed_moving_average_core.sv
// Top level of the windowed moving average core.
// Each transaction on req carries one (time, sample) pair; once the window of window_len
// pairs is full, each transaction gives one result on rsp: the truncated mean sample and the
// midpoint time. A transaction that gives no result goes through capture, delay-line read and
// window update; one that gives a result adds 22 restoring-divider steps (one quotient bit per
// cycle) and an output load, which waits while the previous result is not yet taken. A new
// transaction is taken while the previous result waits in the output register. Writing
// csr_wr_data empties the window; a length of zero acts as 1 and lengths above 64 act as 64.
module windowed_moving_average_core import wma_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [X_W+Y_W-1:0]  req_tdata,   // x_value [31:0], y_value [47:32]
   input  logic                req_tuser,   // first_of_series
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [X_W+Y_W-1:0]  rsp_tdata,   // avg_y [15:0], mid_x [47:16]
   input  logic                csr_wr_en,
   input  logic [LEN_W-1:0]    csr_wr_data  // window_len
);

   wma_cmd_type  cmd;
   wma_stat_type stat;

   wma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   wma_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .cmd         (cmd),
      .stat        (stat)
   );

`ifndef ASSERT_OFF
   // An accepted transaction keeps the core busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("core ready directly after accepting a transaction");

   // A result appears only while a transaction is in progress
   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result raised while the core was idle");
`endif

endmodule
